@@ rtl/query_parameter_parser_unit_assert.svh @@
//------------------------------------------------------------------------------
// Query parameter parser assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is high.
//------------------------------------------------------------------------------
`ifndef QUERY_PARAMETER_PARSER_UNIT_ASSERT_SVH
`define QUERY_PARAMETER_PARSER_UNIT_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent
`define QPP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after its antecedent
`define QPP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/qpp_pkg.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Query parameter parser package
// Field widths, character constants, key text and the types shared by the
// parser stages.
//------------------------------------------------------------------------------
package qpp_pkg;

   localparam int CH_WIDTH    = 8;
   localparam int COUNT_WIDTH = 16;
   localparam int BATON_WIDTH = 8;
   localparam int ACC_WIDTH   = 17;
   localparam int POS_WIDTH   = 4;
   localparam int KEY_BYTES   = 8;
   localparam int PROD_WIDTH  = 21;

   localparam logic [CH_WIDTH-1:0] CHAR_AMP   = 8'h26;
   localparam logic [CH_WIDTH-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CH_WIDTH-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CH_WIDTH-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CH_WIDTH-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CH_WIDTH-1:0] CASE_OFFSET  = 8'h20;

   localparam logic [ACC_WIDTH-1:0]   ACC_SAT         = 17'd65536;
   localparam logic [ACC_WIDTH-1:0]   BATON_MAX       = 17'd255;
   localparam logic [COUNT_WIDTH-1:0] MAX_COUNT_RESET = 16'd10;
   localparam logic [COUNT_WIDTH-1:0] COUNT_DEFAULT   = 16'd1;
   localparam logic [BATON_WIDTH-1:0] BATON_DEFAULT   = 8'd1;

   // Key text, left-justified, lower case
   localparam logic [KEY_BYTES*8-1:0] VERSION_TEXT = "version=";
   localparam logic [KEY_BYTES*8-1:0] BATON_TEXT   = {"baton=", 16'h0000};
   localparam logic [KEY_BYTES*8-1:0] COUNT_TEXT   = {"count=", 16'h0000};
   localparam logic [POS_WIDTH-1:0]   VERSION_LEN  = 4'd8;
   localparam logic [POS_WIDTH-1:0]   SHORT_KEY_LEN = 4'd6;

   typedef enum logic [2:0] {
      PH_KEY   = 3'b001,
      PH_VALUE = 3'b010,
      PH_SKIP  = 3'b100
   } phase_type;

   typedef enum logic [1:0] {
      KEY_VERSION = 2'd0,
      KEY_BATON   = 2'd1,
      KEY_COUNT   = 2'd2
   } key_choice_type;

   typedef struct packed {
      logic [CH_WIDTH-1:0] ch;
      logic                char_valid;
      logic                last;
   } item_type;

   typedef struct packed {
      logic                   ok;
      logic [COUNT_WIDTH-1:0] count;
      logic [BATON_WIDTH-1:0] baton;
   } result_type;

   function automatic logic [CH_WIDTH-1:0] to_lower(input logic [CH_WIDTH-1:0] c);
      logic [CH_WIDTH-1:0] r;
      r = c;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

   function automatic logic [CH_WIDTH-1:0] key_char(input key_choice_type choice,
                                                    input logic [POS_WIDTH-1:0] pos);
      logic [KEY_BYTES*8-1:0] text;
      logic [2:0]             idx;
      case (choice)
         KEY_VERSION: text = VERSION_TEXT;
         KEY_BATON:   text = BATON_TEXT;
         default:     text = COUNT_TEXT;
      endcase
      idx = 3'(KEY_BYTES - 1) - pos[2:0];
      return text[{idx, 3'b000} +: 8];
   endfunction

   function automatic logic [POS_WIDTH-1:0] key_len(input key_choice_type choice);
      logic [POS_WIDTH-1:0] r;
      case (choice)
         KEY_VERSION: r = VERSION_LEN;
         default:     r = SHORT_KEY_LEN;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/qpp_req_if.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Query parameter parser request channel
// Valid/ready channel carrying one query character per transaction.
//------------------------------------------------------------------------------
interface qpp_req_if;
   import qpp_pkg::*;

   logic                valid;
   logic                ready;
   logic [CH_WIDTH-1:0] ch;
   logic                char_valid;
   logic                last;

   modport source (output valid, ch, char_valid, last, input ready);
   modport sink   (input valid, ch, char_valid, last, output ready);
endinterface

@@ rtl/qpp_rsp_if.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Query parameter parser response channel
// Valid/ready channel carrying one parse result per transaction.
//------------------------------------------------------------------------------
interface qpp_rsp_if;
   import qpp_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   ok;
   logic [COUNT_WIDTH-1:0] count;
   logic [BATON_WIDTH-1:0] baton;

   modport source (output valid, ok, count, baton, input ready);
   modport sink   (input valid, ok, count, baton, output ready);
endinterface

@@ rtl/query_parameter_parser_unit.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Query parameter parser unit
// Parses version=, baton= and count= keys from a streamed query string.
//------------------------------------------------------------------------------
// Send the query one character per request transaction, with last set on the
// final one; a transaction with char_valid low and last high ends an empty
// query. Exactly one response follows each last transaction, giving ok, count
// and baton (count and baton read zero when ok is low). The unit accepts one
// character every cycle unless a last character waits on a held response;
// each character passes from the input register through the combinational key
// matcher and times-ten accumulator into the state registers, and a result is
// loaded into the response register when its last character leaves the input
// register, which raises response valid. The response register decouples the
// two sides; a stalled response only holds back a following last character.
// max_count is set through csr_wr_en/csr_wr_data and resets to 10; write it
// only while no query is in flight, which the block does not enforce.
//------------------------------------------------------------------------------
module query_parameter_parser_unit (
   input  logic                             clock,
   input  logic                             reset,
   qpp_req_if.sink                          req_chan,
   qpp_rsp_if.source                        rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [qpp_pkg::COUNT_WIDTH-1:0]  csr_wr_data
);
   import qpp_pkg::*;

   logic       item_valid;
   item_type   item;
   logic       advance;
   logic       load;
   logic       out_free;
   result_type result;

   // Register incoming characters
   qpp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // Match keys, accumulate values and form the result
   qpp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_valid  (item_valid),
      .item        (item),
      .out_free    (out_free),
      .advance     (advance),
      .load        (load),
      .result      (result)
   );

   // Register and present results
   qpp_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .result   (result),
      .out_free (out_free),
      .rsp_chan (rsp_chan)
   );

endmodule

@@ rtl/qpp_in_stage.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Query parameter parser input stage
// Registers one request transaction and holds it until the parser advances.
//------------------------------------------------------------------------------
module qpp_in_stage (
   input  logic               clock,
   input  logic               reset,
   qpp_req_if.sink            req_chan,
   input  logic               advance,
   output logic               item_valid,
   output qpp_pkg::item_type  item
);
   import qpp_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;

   // Take a new transaction when the slot is empty or drains this cycle
   assign req_chan.ready = !valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in           = 1'b1;
         item_in.ch         = req_chan.ch;
         item_in.char_valid = req_chan.char_valid;
         item_in.last       = req_chan.last;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   // Hold control state under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ rtl/qpp_parser.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Query parameter parser core
// Key matcher, decimal value accumulator and result formation, one
// character per cycle unless a last character waits for a free result register.
//------------------------------------------------------------------------------
`include "query_parameter_parser_unit_assert.svh"

module qpp_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [qpp_pkg::COUNT_WIDTH-1:0]     csr_wr_data,
   input  logic                                item_valid,
   input  qpp_pkg::item_type                   item,
   input  logic                                out_free,
   output logic                                advance,
   output logic                                load,
   output qpp_pkg::result_type                 result
);
   import qpp_pkg::*;

   logic [COUNT_WIDTH-1:0] max_count_ff;
   phase_type              phase_ff, phase_in, phase_mid;
   logic [POS_WIDTH-1:0]   key_pos_ff, key_pos_in, key_pos_mid;
   key_choice_type         choice_ff, choice_in, choice_mid;
   logic [ACC_WIDTH-1:0]   acc_ff, acc_in, acc_mid;
   logic                   seen_ff, seen_in, seen_mid;
   logic                   failed_ff, failed_in, failed_mid;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [BATON_WIDTH-1:0] baton_ff, baton_in;

   logic                   take;
   logic                   is_amp;
   logic                   is_digit;
   logic [CH_WIDTH-1:0]    lc;
   logic [PROD_WIDTH-1:0]  prod;
   logic [ACC_WIDTH-1:0]   acc_sat;
   logic [POS_WIDTH-1:0]   pos_next;
   logic                   value_amp;
   logic                   finish;
   logic                   fin_fail;
   logic [COUNT_WIDTH-1:0] fin_count;
   logic [BATON_WIDTH-1:0] fin_baton;

   // Advance when the item causes no result or the result register is free
   assign advance = item_valid && (!item.last || out_free);
   assign load    = advance && item.last;

   // Character classes and the times-ten accumulate
   assign take     = item.char_valid && !failed_ff;
   assign is_amp   = (item.ch == CHAR_AMP);
   assign is_digit = (item.ch >= CHAR_ZERO) && (item.ch <= CHAR_NINE);
   assign lc       = to_lower(item.ch);
   assign prod     = PROD_WIDTH'({acc_ff, 3'b000}) + PROD_WIDTH'({acc_ff, 1'b0})
                   + PROD_WIDTH'(item.ch - CHAR_ZERO);
   assign acc_sat  = (prod > PROD_WIDTH'(ACC_SAT)) ? ACC_SAT : prod[ACC_WIDTH-1:0];
   assign pos_next = key_pos_ff + 4'd1;

   // Step the key/value machine by one character
   always_comb begin
      phase_mid   = phase_ff;
      key_pos_mid = key_pos_ff;
      choice_mid  = choice_ff;
      acc_mid     = acc_ff;
      seen_mid    = seen_ff;
      failed_mid  = failed_ff;
      value_amp   = 1'b0;
      if (take) begin
         case (phase_ff)
            PH_VALUE: begin
               if (is_amp) begin
                  value_amp   = 1'b1;
                  phase_mid   = PH_KEY;
                  key_pos_mid = '0;
               end else if (is_digit) begin
                  acc_mid  = acc_sat;
                  seen_mid = 1'b1;
               end else begin
                  failed_mid = 1'b1;
               end
            end
            PH_SKIP: begin
               if (is_amp) begin
                  phase_mid   = PH_KEY;
                  key_pos_mid = '0;
               end
            end
            PH_KEY: begin
               if (key_pos_ff == '0) begin
                  if (lc == key_char(KEY_VERSION, '0)) begin
                     choice_mid  = KEY_VERSION;
                     key_pos_mid = 4'd1;
                  end else if (lc == key_char(KEY_BATON, '0)) begin
                     choice_mid  = KEY_BATON;
                     key_pos_mid = 4'd1;
                  end else if (lc == key_char(KEY_COUNT, '0)) begin
                     choice_mid  = KEY_COUNT;
                     key_pos_mid = 4'd1;
                  end else if (!is_amp) begin
                     phase_mid = PH_SKIP;
                  end
               end else if (lc == key_char(choice_ff, key_pos_ff)) begin
                  key_pos_mid = pos_next;
                  if (pos_next == key_len(choice_ff)) begin
                     phase_mid = PH_VALUE;
                     acc_mid   = '0;
                     seen_mid  = 1'b0;
                  end
               end else if (is_amp) begin
                  key_pos_mid = '0;
               end else begin
                  phase_mid = PH_SKIP;
               end
            end
            default: begin
               phase_mid = PH_SKIP;
            end
         endcase
      end
   end

   // Close a value on '&' or at the end of the query
   assign finish = value_amp || (item.last && !failed_mid && (phase_mid == PH_VALUE));

   always_comb begin
      fin_fail  = 1'b0;
      fin_count = count_ff;
      fin_baton = baton_ff;
      if (finish) begin
         if (!seen_mid) begin
            fin_fail = 1'b1;
         end else begin
            case (choice_mid)
               KEY_VERSION: begin
                  fin_fail = (acc_mid != '0);
               end
               KEY_BATON: begin
                  if (acc_mid == '0 || acc_mid > BATON_MAX) begin
                     fin_fail = 1'b1;
                  end else begin
                     fin_baton = acc_mid[BATON_WIDTH-1:0];
                  end
               end
               default: begin
                  if (acc_mid == '0 || acc_mid > ACC_WIDTH'(max_count_ff)) begin
                     fin_fail = 1'b1;
                  end else begin
                     fin_count = acc_mid[COUNT_WIDTH-1:0];
                  end
               end
            endcase
         end
      end
   end

   // Form the result and drop back to the reset state on the last item
   always_comb begin
      result.ok    = !(failed_mid || fin_fail);
      result.count = result.ok ? fin_count : '0;
      result.baton = result.ok ? fin_baton : '0;

      phase_in  = phase_mid;
      key_pos_in = key_pos_mid;
      choice_in = choice_mid;
      acc_in    = acc_mid;
      seen_in   = seen_mid;
      failed_in = failed_mid || fin_fail;
      count_in  = fin_count;
      baton_in  = fin_baton;
      if (item.last) begin
         phase_in   = PH_KEY;
         key_pos_in = '0;
         choice_in  = KEY_VERSION;
         acc_in     = '0;
         seen_in    = 1'b0;
         failed_in  = 1'b0;
         count_in   = COUNT_DEFAULT;
         baton_in   = BATON_DEFAULT;
      end
   end

   // Hold the configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_count_ff <= MAX_COUNT_RESET;
      end else if (csr_wr_en) begin
         max_count_ff <= csr_wr_data;
      end
   end

   // Advance the parse state once per consumed item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_KEY;
         key_pos_ff <= '0;
         choice_ff  <= KEY_VERSION;
         acc_ff     <= '0;
         seen_ff    <= 1'b0;
         failed_ff  <= 1'b0;
         count_ff   <= COUNT_DEFAULT;
         baton_ff   <= BATON_DEFAULT;
      end else if (advance) begin
         phase_ff   <= phase_in;
         key_pos_ff <= key_pos_in;
         choice_ff  <= choice_in;
         acc_ff     <= acc_in;
         seen_ff    <= seen_in;
         failed_ff  <= failed_in;
         count_ff   <= count_in;
         baton_ff   <= baton_in;
      end
   end

   `QPP_ASSERT_SAME(a_load_only_on_last, clock, reset, load, item_valid && item.last && out_free, "result loaded without a last item or a free result slot")
   `QPP_ASSERT_SAME(a_reject_zero_fields, clock, reset, load && !result.ok, result.count == '0 && result.baton == '0, "rejected query carries nonzero fields")
   `QPP_ASSERT_SAME(a_accept_nonzero_fields, clock, reset, load && result.ok, result.count != '0 && result.baton != '0, "accepted query carries a zero field")
   `QPP_ASSERT_NEXT(a_clear_after_last, clock, reset, load, phase_ff == PH_KEY && key_pos_ff == '0 && !failed_ff && count_ff == COUNT_DEFAULT && baton_ff == BATON_DEFAULT, "parse state not cleared after the last item")

endmodule

@@ rtl/qpp_out_stage.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Query parameter parser output stage
// Result register that drives the response channel and holds a stalled
// transaction.
//------------------------------------------------------------------------------
module qpp_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  qpp_pkg::result_type  result,
   output logic                 out_free,
   qpp_rsp_if.source            rsp_chan
);
   import qpp_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff, result_in;

   // Free when empty or when the held transaction leaves this cycle
   assign out_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (load) begin
         valid_in  = 1'b1;
         result_in = result;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   // Hold control state under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_chan.valid = valid_ff;
   assign rsp_chan.ok    = result_ff.ok;
   assign rsp_chan.count = result_ff.count;
   assign rsp_chan.baton = result_ff.baton;

endmodule
